>>> src/vdl_pkg.sv
// shared constants and types for the versioned dependency list block
`timescale 1ns / 1ps
package vdl_pkg;

	localparam int NODES   = 1024;
	localparam int SLOTS   = 1024;
	localparam int MAX_OUT = 64;

	localparam int NODE_W = $clog2(NODES);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LINK_W = SLOT_W + 1;
	localparam int VER_W  = 32;
	localparam int LIM_W  = 7;
	localparam int CNT_W  = $clog2(MAX_OUT + 1);

	localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_GET   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

endpackage

>>> src/vdl_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module vdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/versioned_dependency_lists_unit.sv
// top level of the versioned dependency list block
// Usage:
// Each node owns a linked list of slots taken from a shared pool with a free
// list. Input words arrive on s_tvalid/s_tready: s_tuser holds the opcode
// (add, clear, get), s_tdata holds node_a, node_b and limit. Results leave on
// m_tvalid/m_tready with m_tlast marking the final result of a word.
// One word is worked on at a time; s_tready is high only while idle.
// Clear finds the tail of the node's list with one slot_next read per hop.
// Get frees each stale slot it visits; each visit is paced by the slot-memory
// read then the version-memory read of the target.
// Results go through one output register, so the next word is taken while a
// result still waits; a stalled receiver holds the walk when a new result must
// be produced.
// After reset the block runs a clearing pass over all NODES (1024) entries of
// the node version and head memories and accepts no word until it ends.
// Slot memories are not cleared; they are always written before being read.
`timescale 1ns / 1ps
module versioned_dependency_lists_unit
	import vdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // node_a[9:0], node_b[19:10], limit[26:20], zero
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status[0], has_item[1], target_id[11:2], zero
	output logic        m_tlast
);

	typedef enum logic [14:0] {
		ST_INIT = 15'b000000000000001,
		ST_IDLE = 15'b000000000000010,
		ST_ADD1 = 15'b000000000000100,
		ST_ADD2 = 15'b000000000001000,
		ST_CLR1 = 15'b000000000010000,
		ST_CLR2 = 15'b000000000100000,
		ST_CLR3 = 15'b000000001000000,
		ST_CLR4 = 15'b000000010000000,
		ST_GET1 = 15'b000000100000000,
		ST_GET2 = 15'b000001000000000,
		ST_GET3 = 15'b000010000000000,
		ST_GET4 = 15'b000100000000000,
		ST_GET5 = 15'b001000000000000,
		ST_GET6 = 15'b010000000000000,
		ST_DONE = 15'b100000000000000
	} state_t;

	state_t state_q;

	// word registers
	logic [NODE_W-1:0] a_q, b_q;
	logic [LIM_W-1:0]  lim_q;
	logic              status_q;

	// pool and walk registers
	logic [LINK_W-1:0] free_head_q, used_q, idx_q, prev_q, head_q, nxt_q, steps_q;
	logic [NODE_W-1:0] clr_q, t_q, pend_t_q;
	logic [VER_W-1:0]  sver_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;

	// output register
	logic              out_valid_q, out_status_q, out_has_q, out_last_q;
	logic [NODE_W-1:0] out_t_q;

	// memory ports
	logic                     nv_we, nh_we, sn_we, sd_we;
	logic [NODE_W-1:0]        nv_waddr, nv_raddr, nh_waddr, nh_raddr;
	logic [SLOT_W-1:0]        sn_waddr, sn_raddr, sd_waddr, sd_raddr;
	logic [VER_W-1:0]         nv_wdata, nv_rdata;
	logic [LINK_W-1:0]        nh_wdata, nh_rdata, sn_wdata, sn_rdata;
	logic [VER_W+NODE_W-1:0]  sd_wdata, sd_rdata;

	logic              emit_v, emit_ok, emit_has, emit_last, accept, live;
	logic [NODE_W-1:0] emit_t;
	logic [LIM_W-1:0]  lim_in;

	vdl_ram #(.WIDTH(VER_W), .DEPTH(NODES)) u_node_ver (
		.clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
		.raddr(nv_raddr), .rdata(nv_rdata));
	vdl_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_node_head (
		.clk(clk), .we(nh_we), .waddr(nh_waddr), .wdata(nh_wdata),
		.raddr(nh_raddr), .rdata(nh_rdata));
	vdl_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_slot_next (
		.clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
		.raddr(sn_raddr), .rdata(sn_rdata));
	vdl_ram #(.WIDTH(VER_W + NODE_W), .DEPTH(SLOTS)) u_slot_data (
		.clk(clk), .we(sd_we), .waddr(sd_waddr), .wdata(sd_wdata),
		.raddr(sd_raddr), .rdata(sd_rdata));

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit_ok  = !out_valid_q || m_tready;
	assign live     = (nv_rdata == sver_q);
	assign lim_in   = (s_tdata[26:20] > LIM_W'(MAX_OUT)) ? LIM_W'(MAX_OUT) : s_tdata[26:20];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - NODE_W - 2){1'b0}}, out_t_q, out_has_q, out_status_q};
	assign m_tlast  = out_last_q;

	// memory addressing, writes and result to emit
	always_comb begin
		nv_we = 1'b0; nv_waddr = a_q; nv_wdata = nv_rdata + VER_W'(1); nv_raddr = a_q;
		nh_we = 1'b0; nh_waddr = a_q; nh_wdata = NIL; nh_raddr = a_q;
		sn_we = 1'b0; sn_waddr = idx_q[SLOT_W-1:0]; sn_wdata = free_head_q;
		sn_raddr = idx_q[SLOT_W-1:0];
		sd_we = 1'b0; sd_waddr = idx_q[SLOT_W-1:0]; sd_wdata = {nv_rdata, b_q};
		sd_raddr = idx_q[SLOT_W-1:0];
		emit_v = 1'b0; emit_has = 1'b0; emit_t = '0; emit_last = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				nv_we = 1'b1; nv_waddr = clr_q; nv_wdata = '0;
				nh_we = 1'b1; nh_waddr = clr_q; nh_wdata = NIL;
			end
			ST_ADD1: begin
				nv_raddr = b_q;
				sn_raddr = free_head_q[SLOT_W-1:0];
			end
			ST_ADD2: begin
				nv_raddr = b_q;
				sn_raddr = free_head_q[SLOT_W-1:0];
				if (free_head_q < NIL) begin
					sd_waddr = free_head_q[SLOT_W-1:0];
					sn_waddr = free_head_q[SLOT_W-1:0];
					nh_wdata = free_head_q;
				end else begin
					sd_waddr = used_q[SLOT_W-1:0];
					sn_waddr = used_q[SLOT_W-1:0];
					nh_wdata = used_q;
				end
				sn_wdata = nh_rdata;
				if (free_head_q < NIL || used_q < NIL) begin
					sd_we = 1'b1; sn_we = 1'b1; nh_we = 1'b1;
				end
			end
			ST_CLR2: begin
				nv_we = 1'b1;
				nh_we = 1'b1;
			end
			ST_CLR4: begin
				if (!(sn_rdata < NIL && steps_q < NIL)) begin
					sn_we = 1'b1;
				end
			end
			ST_GET4: begin
				nv_raddr = sd_rdata[NODE_W-1:0];
			end
			ST_GET5: begin
				nv_raddr = t_q;
				if (live) begin
					if (cnt_q < CNT_W'(lim_q) && pend_valid_q) begin
						emit_v = 1'b1; emit_has = 1'b1; emit_t = pend_t_q;
					end
				end else if (prev_q < NIL) begin
					sn_we = 1'b1; sn_waddr = prev_q[SLOT_W-1:0]; sn_wdata = nxt_q;
				end else begin
					nh_we = 1'b1; nh_wdata = nxt_q;
				end
			end
			ST_GET6: begin
				sn_we = 1'b1;
			end
			ST_DONE: begin
				emit_v = 1'b1; emit_has = pend_valid_q; emit_last = 1'b1;
				emit_t = pend_valid_q ? pend_t_q : '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			clr_q        <= '0;
			free_head_q  <= NIL;
			used_q       <= '0;
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
			status_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						a_q          <= s_tdata[9:0];
						b_q          <= s_tdata[19:10];
						lim_q        <= lim_in;
						status_q     <= 1'b0;
						pend_valid_q <= 1'b0;
						unique case (opcode_t'(s_tuser))
							OP_ADD:   state_q <= ST_ADD1;
							OP_CLEAR: state_q <= ST_CLR1;
							OP_GET:   state_q <= ST_GET1;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: begin
					if (free_head_q < NIL) begin
						free_head_q <= sn_rdata;
					end else if (used_q < NIL) begin
						used_q <= used_q + LINK_W'(1);
					end else begin
						status_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_CLR1: state_q <= ST_CLR2;
				ST_CLR2: begin
					head_q  <= nh_rdata;
					idx_q   <= nh_rdata;
					steps_q <= '0;
					state_q <= (nh_rdata < NIL) ? ST_CLR3 : ST_DONE;
				end
				ST_CLR3: state_q <= ST_CLR4;
				ST_CLR4: begin
					if (sn_rdata < NIL && steps_q < NIL) begin
						idx_q   <= sn_rdata;
						steps_q <= steps_q + LINK_W'(1);
						state_q <= ST_CLR3;
					end else begin
						free_head_q <= head_q;
						state_q     <= ST_DONE;
					end
				end
				ST_GET1: state_q <= ST_GET2;
				ST_GET2: begin
					idx_q   <= nh_rdata;
					prev_q  <= NIL;
					cnt_q   <= '0;
					steps_q <= '0;
					state_q <= ST_GET3;
				end
				ST_GET3: begin
					state_q <= (idx_q < NIL && steps_q < NIL) ? ST_GET4 : ST_DONE;
				end
				ST_GET4: begin
					nxt_q   <= sn_rdata;
					t_q     <= sd_rdata[NODE_W-1:0];
					sver_q  <= sd_rdata[VER_W+NODE_W-1:NODE_W];
					state_q <= ST_GET5;
				end
				ST_GET5: begin
					if (live) begin
						if (!(cnt_q < CNT_W'(lim_q) && pend_valid_q && !emit_ok)) begin
							if (cnt_q < CNT_W'(lim_q)) begin
								pend_t_q     <= t_q;
								pend_valid_q <= 1'b1;
								cnt_q        <= cnt_q + CNT_W'(1);
							end
							prev_q  <= idx_q;
							idx_q   <= nxt_q;
							steps_q <= steps_q + LINK_W'(1);
							state_q <= ST_GET3;
						end
					end else begin
						state_q <= ST_GET6;
					end
				end
				ST_GET6: begin
					free_head_q <= idx_q;
					idx_q       <= nxt_q;
					steps_q     <= steps_q + LINK_W'(1);
					state_q     <= ST_GET3;
				end
				ST_DONE: begin
					if (emit_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_v && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v && emit_ok) begin
			out_status_q <= (state_q == ST_DONE) ? status_q : 1'b0;
			out_has_q    <= emit_has;
			out_t_q      <= emit_t;
			out_last_q   <= emit_last;
		end
	end

	// free list only holds slots already taken from the unused region
	a_free_below_used: assert property (@(posedge clk) disable iff (!arst_n)
		!(free_head_q < NIL) || (free_head_q < used_q))
		else $error("free head points beyond used slots");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NIL)
		else $error("slot use count out of range");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GET3) |-> (cnt_q <= CNT_W'(lim_q)))
		else $error("get emitted more than its limit");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> (!out_valid_q && !s_tready))
		else $error("activity during clearing pass");

endmodule
